@@ src/efws_pkg.sv @@
`default_nettype none
package efws_pkg;

	// fixed field widths
	localparam int COST_W  = 32;
	localparam int TIME_W  = 64;
	localparam int CNT_W   = 5;
	localparam int WID_W   = 4;
	localparam int TDATA_W = 72;

	// largest heap the 5-bit worker count can address
	localparam int CNT_MAX = 31;

	// free time of a saturated worker
	localparam logic [TIME_W-1:0] TIME_SAT = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SIFT,
		ST_EMIT
	} efws_state_t;

endpackage
`default_nettype wire

@@ src/efws_heap_mem.sv @@
`default_nettype none
// Heap slot storage: one write port, two registered read ports.
// A slot never written since reset or the last clear reads as its reset
// value (free time zero, worker equal to slot number).
module efws_heap_mem #(
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     clr,
	input  wire logic                                     wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [efws_pkg::TIME_W-1:0]              wr_time,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_wk,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
	output logic      [efws_pkg::TIME_W-1:0]              rd_time_a,
	output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_wk_a,
	output logic      [efws_pkg::TIME_W-1:0]              rd_time_b,
	output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_wk_b
);
	import efws_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [TIME_W-1:0] mem_time [DEPTH];
	logic [IDX_W-1:0]  mem_wk   [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	logic [TIME_W-1:0] dat_time_a_q, dat_time_b_q;
	logic [IDX_W-1:0]  dat_wk_a_q, dat_wk_b_q;
	logic [IDX_W-1:0]  addr_a_q, addr_b_q;
	logic              hit_a_q, hit_b_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_time[wr_addr] <= wr_time;
			mem_wk[wr_addr]   <= wr_wk;
		end
		dat_time_a_q <= mem_time[rd_addr_a];
		dat_wk_a_q   <= mem_wk[rd_addr_a];
		dat_time_b_q <= mem_time[rd_addr_b];
		dat_wk_b_q   <= mem_wk[rd_addr_b];
		addr_a_q     <= rd_addr_a;
		addr_b_q     <= rd_addr_b;
	end

	// written-since-clear flags; a clear also masks reads in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			hit_a_q <= vld_q[rd_addr_a] & ~clr;
			hit_b_q <= vld_q[rd_addr_b] & ~clr;
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// unwritten slots read as their reset value
	assign rd_time_a = hit_a_q ? dat_time_a_q : '0;
	assign rd_wk_a   = hit_a_q ? dat_wk_a_q   : addr_a_q;
	assign rd_time_b = hit_b_q ? dat_time_b_q : '0;
	assign rd_wk_b   = hit_b_q ? dat_wk_b_q   : addr_b_q;

endmodule
`default_nettype wire

@@ src/earliest_free_worker_scheduler.sv @@
`default_nettype none
// Earliest-free worker scheduler.
// Input stream s_axis: one job per transfer, cost in tdata, tuser[0] set on
// the first job of a batch (all workers free at zero, slot i holds worker i).
// Output stream m_axis: one result per job, the chosen worker (lowest free
// time, lower worker number on a tie) and the job's start time.
// cfg_*: writes worker_count (0 acts as 1, large values clamp to the heap
// size); cfg_ready is always high. Write it only while the block is idle.
// Timing: after a job is accepted, the ROOT state takes the heap root and
// charges the cost, then the sift-down runs one heap level per cycle
// through a single compare unit fed by the two child read ports of the
// slot memory, then the EMIT state hands the result to the output
// register. s_axis_tready stays low from acceptance until EMIT has handed
// the result on and the block is idle again.
// A result waiting in the output register does not stop the next job from
// being accepted; only its own hand-off waits while m_axis_tready is low.
// Reset: no result pending, worker_count = 1, all workers free at zero.
module earliest_free_worker_scheduler #(
	parameter int MAX_WORKERS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// job_cost [31:0]
	input  wire logic [efws_pkg::COST_W-1:0]  s_axis_tdata,
	// new_batch [0]
	input  wire logic [0:0]                   s_axis_tuser,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// worker_id [3:0], start_time [67:4], zero [71:68]
	output logic      [efws_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic [efws_pkg::CNT_W-1:0]   cfg_data,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready
);
	import efws_pkg::*;

	localparam int DEPTH = (MAX_WORKERS < CNT_MAX) ? MAX_WORKERS : CNT_MAX;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W  = IDX_W + 2;
	localparam int KEY_W = TIME_W + IDX_W;
	localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(DEPTH);

	efws_state_t state_q, state_d;

	logic [CNT_W-1:0]  worker_count_q;
	logic [COST_W-1:0] cost_q;
	logic [CNT_W-1:0]  size_q;
	logic [IDX_W-1:0]  pos_q;
	logic [TIME_W-1:0] cur_time_q;
	logic [IDX_W-1:0]  cur_wk_q;
	logic [TIME_W-1:0] res_time_q;
	logic [IDX_W-1:0]  res_wk_q;
	logic [TIME_W-1:0] out_time_q;
	logic [WID_W-1:0]  out_wk_q;
	logic              out_vld_q;

	logic              in_xfer;
	logic              out_load;
	logic [CNT_W-1:0]  size_d;

	// memory interface
	logic              mem_clr;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [TIME_W-1:0] mem_wtime;
	logic [IDX_W-1:0]  mem_wwk;
	logic [IDX_W-1:0]  mem_raddr_a, mem_raddr_b;
	logic [TIME_W-1:0] rd_time_a, rd_time_b;
	logic [IDX_W-1:0]  rd_wk_a, rd_wk_b;

	// compare unit
	logic [CH_W-1:0]   lc, rc, best, best_lc, best_rc;
	logic              lc_ok, rc_ok, l_lt_c, r_lt_c, r_lt_l, pick_r, move;
	logic [KEY_W-1:0]  key_cur, key_l, key_r;
	logic [TIME_W:0]   sum;
	logic [WID_W+IDX_W-1:0] wk_ext;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_axis_tvalid & s_axis_tready;

	// clamp worker count to 1..DEPTH
	always_comb begin
		if (worker_count_q == '0) begin
			size_d = CNT_W'(1);
		end else if (worker_count_q > SIZE_MAX) begin
			size_d = SIZE_MAX;
		end else begin
			size_d = worker_count_q;
		end
	end

	// saturating update of the root free time
	assign sum = {1'b0, rd_time_a} + {{(TIME_W - COST_W + 1){1'b0}}, cost_q};

	// child compare at the current slot
	assign lc      = {1'b0, pos_q, 1'b1};
	assign rc      = lc + CH_W'(1);
	assign lc_ok   = lc < CH_W'(size_q);
	assign rc_ok   = rc < CH_W'(size_q);
	assign key_cur = {cur_time_q, cur_wk_q};
	assign key_l   = {rd_time_a, rd_wk_a};
	assign key_r   = {rd_time_b, rd_wk_b};
	assign l_lt_c  = lc_ok & (key_l < key_cur);
	assign r_lt_c  = rc_ok & (key_r < key_cur);
	assign r_lt_l  = rc_ok & (key_r < key_l);
	assign pick_r  = l_lt_c ? r_lt_l : r_lt_c;
	assign move    = l_lt_c | r_lt_c;
	assign best    = pick_r ? rc : lc;
	assign best_lc = {best[CH_W-2:0], 1'b1};
	assign best_rc = best_lc + CH_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_ROOT;
			ST_ROOT: state_d = ST_SIFT;
			ST_SIFT: if (!move) state_d = ST_EMIT;
			ST_EMIT: if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mem_clr       = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = pos_q;
		mem_wtime     = cur_time_q;
		mem_wwk       = cur_wk_q;
		mem_raddr_a   = '0;
		mem_raddr_b   = '0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				mem_clr       = in_xfer & s_axis_tuser[0];
			end
			ST_ROOT: begin
				mem_raddr_a = IDX_W'(1);
				mem_raddr_b = IDX_W'(2);
			end
			ST_SIFT: begin
				mem_we      = 1'b1;
				mem_raddr_a = best_lc[IDX_W-1:0];
				mem_raddr_b = best_rc[IDX_W-1:0];
				if (move) begin
					mem_wtime = pick_r ? rd_time_b : rd_time_a;
					mem_wwk   = pick_r ? rd_wk_b : rd_wk_a;
				end
			end
			ST_EMIT: out_load = !out_vld_q || m_axis_tready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			worker_count_q <= CNT_W'(1);
			out_vld_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				worker_count_q <= cfg_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cost_q <= s_axis_tdata;
			size_q <= size_d;
		end
		if (state_q == ST_ROOT) begin
			res_time_q <= rd_time_a;
			res_wk_q   <= rd_wk_a;
			cur_wk_q   <= rd_wk_a;
			cur_time_q <= sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
			pos_q      <= '0;
		end
		if (state_q == ST_SIFT && move) begin
			pos_q <= best[IDX_W-1:0];
		end
		if (out_load) begin
			out_time_q <= res_time_q;
			out_wk_q   <= wk_ext[WID_W-1:0];
		end
	end

	assign wk_ext = {{WID_W{1'b0}}, res_wk_q};

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(TDATA_W - TIME_W - WID_W){1'b0}}, out_time_q, out_wk_q};

	efws_heap_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (mem_clr),
		.wr_en     (mem_we),
		.wr_addr   (mem_waddr),
		.wr_time   (mem_wtime),
		.wr_wk     (mem_wwk),
		.rd_addr_a (mem_raddr_a),
		.rd_addr_b (mem_raddr_b),
		.rd_time_a (rd_time_a),
		.rd_wk_a   (rd_wk_a),
		.rd_time_b (rd_time_b),
		.rd_wk_b   (rd_wk_b)
	);

endmodule
`default_nettype wire

@@ src/efws_checker.sv @@
`default_nettype none
module efws_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_axis_tvalid,
	input wire logic                         s_axis_tready,
	input wire logic                         m_axis_tvalid,
	input wire logic                         m_axis_tready,
	input wire logic [efws_pkg::TDATA_W-1:0] m_axis_tdata,
	input wire logic                         cfg_ready
);
	import efws_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// a job keeps the input closed while it is being placed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input reopened during sift");

	// padding above start_time is zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:TIME_W+WID_W] == '0)
		else $error("nonzero padding");

	// configuration is always taken
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");

endmodule

bind earliest_free_worker_scheduler efws_checker u_efws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
`default_nettype wire

@@ tb/sv/schedule_checker.sv @@
`default_nettype none
// Watches the job, result and worker-count channels, keeps its own copy of
// the worker heap and checks every result against the predicted assignment.
module schedule_checker #(
	parameter int MAX_WORKERS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [efws_pkg::COST_W-1:0]         s_axis_tdata,
	input  wire logic [0:0]                          s_axis_tuser,
	input  wire logic                                s_axis_tvalid,
	input  wire logic                                s_axis_tready,
	input  wire logic [efws_pkg::TDATA_W-1:0]        m_axis_tdata,
	input  wire logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic [efws_pkg::CNT_W-1:0]          cfg_data,
	input  wire logic                                cfg_valid,
	input  wire logic                                cfg_ready,
	output int                                       mismatch_count,
	output int                                       jobs_in_flight,
	output int                                       results_checked
);
	import efws_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int PAD_LO      = WID_W + TIME_W;

	typedef struct packed {
		logic [WID_W-1:0]  worker;
		logic [TIME_W-1:0] start;
	} assignment_t;

	// model heap: free time and worker per slot
	logic [TIME_W-1:0] free_at [MAX_WORKERS];
	logic [WID_W-1:0]  owner   [MAX_WORKERS];
	logic [CNT_W-1:0]  worker_count;

	assignment_t pending_assignments [$];
	assignment_t want;
	logic [WID_W-1:0]  got_worker;
	logic [TIME_W-1:0] got_start;
	logic [TDATA_W-PAD_LO-1:0] got_pad;

	// all workers free at zero, slot i holds worker i
	function automatic void clear_heap();
		for (int k = 0; k < MAX_WORKERS; k++) begin
			free_at[k] = '0;
			owner[k]   = k[WID_W-1:0];
		end
	endfunction

	// slot a belongs above slot b
	function automatic logic earlier_slot(input int a, input int b);
		if (free_at[a] != free_at[b])
			return free_at[a] < free_at[b];
		return owner[a] < owner[b];
	endfunction

	// hand the job to the root worker, charge its cost, sift the root down
	function automatic assignment_t assign_job(input logic [COST_W-1:0] cost, input logic batch);
		int size;
		int pos;
		int best;
		int lc;
		int rc;
		logic [TIME_W-1:0] tf;
		logic [WID_W-1:0]  tw;
		assignment_t res;
		size = worker_count;
		if (size == 0)
			size = 1;
		if (size > MAX_WORKERS)
			size = MAX_WORKERS;
		if (batch)
			clear_heap();
		res.worker = owner[0];
		res.start  = free_at[0];
		if (free_at[0] > TIME_SAT - {{(TIME_W-COST_W){1'b0}}, cost})
			free_at[0] = TIME_SAT;
		else
			free_at[0] = free_at[0] + cost;
		pos = 0;
		forever begin
			best = pos;
			lc = 2 * pos + 1;
			rc = 2 * pos + 2;
			if (lc < size && earlier_slot(lc, best))
				best = lc;
			if (rc < size && earlier_slot(rc, best))
				best = rc;
			if (best == pos)
				break;
			tf = free_at[pos];
			tw = owner[pos];
			free_at[pos] = free_at[best];
			owner[pos]   = owner[best];
			free_at[best] = tf;
			owner[best]   = tw;
			pos = best;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_heap();
			worker_count = CNT_W'(1);
			pending_assignments.delete();
			jobs_in_flight = 0;
			mismatch_count = 0;
			results_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				worker_count = cfg_data;

			// results leave before a job accepted on the same edge is predicted
			if (m_axis_tvalid && m_axis_tready) begin
				got_worker = m_axis_tdata[WID_W-1:0];
				got_start  = m_axis_tdata[WID_W +: TIME_W];
				got_pad    = m_axis_tdata[TDATA_W-1:PAD_LO];
				if (pending_assignments.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("unexpected result: worker %0d start %0d",
							got_worker, got_start);
					mismatch_count++;
				end else begin
					want = pending_assignments.pop_front();
					results_checked++;
					if (got_worker !== want.worker || got_start !== want.start ||
						got_pad !== '0) begin
						if (mismatch_count < MAX_REPORTS)
							$display("result %0d: want wk %0d t %0d, got wk %0d t %0d pad %h",
								results_checked, want.worker, want.start,
								got_worker, got_start, got_pad);
						mismatch_count++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				pending_assignments.push_back(assign_job(s_axis_tdata, s_axis_tuser[0]));

			jobs_in_flight = pending_assignments.size();
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
	import efws_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int IDLE_PAUSE  = 12;
	localparam int PHASES      = 12;
	localparam int PHASE_JOBS  = 50;

	// receiver stall patterns
	localparam logic [1:0] RX_ALWAYS   = 2'd0;
	localparam logic [1:0] RX_MOSTLY   = 2'd1;
	localparam logic [1:0] RX_PERIODIC = 2'd2;
	localparam logic [1:0] RX_COIN     = 2'd3;

	logic               clk;
	logic               arst_n;
	logic [COST_W-1:0]  s_axis_tdata;   // job_cost [31:0]
	logic [0:0]         s_axis_tuser;   // new_batch [0]
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;   // worker_id [3:0], start_time [67:4]
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [CNT_W-1:0]   cfg_data;
	logic               cfg_valid;
	logic               cfg_ready;

	int mismatch_count;
	int jobs_in_flight;
	int results_checked;

	logic [1:0] stall_mode;
	logic [4:0] stall_phase;
	int quiet_cycles;
	int burst_left;
	bit gaps_on;
	int jobs_sent;
	int batch_starts;
	int count_writes;

	earliest_free_worker_scheduler #(.MAX_WORKERS(16)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_data      (cfg_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready)
	);

	schedule_checker #(.MAX_WORKERS(16)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.cfg_data        (cfg_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.mismatch_count  (mismatch_count),
		.jobs_in_flight  (jobs_in_flight),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_phase   <= '0;
			m_axis_tready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 5'd1;
			case (stall_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: m_axis_tready <= (stall_phase >= 5'd12);
				RX_COIN: m_axis_tready <= ($urandom_range(0, 1) != 0);
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	// watchdog: ends a run that stops moving
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles", quiet_cycles);
				$display("earliest_free_worker_scheduler: mismatch");
				$finish;
			end
		end
	end

	// one job transfer, then, with gaps on, a gap when the burst runs out
	task automatic send_job(input logic [COST_W-1:0] cost, input logic batch);
		int gap;
		s_axis_tdata  <= cost;
		s_axis_tuser  <= batch;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		jobs_sent++;
		if (batch)
			batch_starts++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = $urandom_range(1, 8);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drain every result, then let the block settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (jobs_in_flight != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		count_writes++;
	endtask

	// small costs make ties common, full range exercises every bit
	function automatic logic [COST_W-1:0] pick_cost();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return $urandom_range(0, 7);
			4, 5: return $urandom_range(0, 1000);
			6: return $urandom();
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	initial begin
		int cnt;
		jobs_sent = 0;
		batch_starts = 0;
		count_writes = 0;
		burst_left = 1;
		gaps_on = 1'b0;
		arst_n = 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		s_axis_tvalid <= 1'b0;
		cfg_data <= '0;
		cfg_valid <= 1'b0;
		stall_mode <= RX_ALWAYS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// jobs before any batch start, reset worker count of one
		send_job(32'd5, 1'b0);
		send_job(32'd0, 1'b0);
		send_job('1, 1'b0);
		wait_idle();

		// full heap, zero-cost ties resolve by worker number
		write_count(5'd16);
		send_job(32'd0, 1'b1);
		send_job(32'd0, 1'b0);
		send_job(32'd3, 1'b0);
		send_job('1, 1'b0);
		send_job(32'd1, 1'b0);
		wait_idle();

		// zero count behaves as one worker
		write_count(5'd0);
		send_job(32'd7, 1'b1);
		send_job(32'd7, 1'b0);
		wait_idle();

		// count above the heap size clamps
		write_count(5'd31);
		send_job(32'd0, 1'b1);
		send_job(32'd2, 1'b0);
		send_job(32'hAAAA_AAAA, 1'b0);
		wait_idle();

		// shrink then grow the heap inside a batch
		write_count(5'd5);
		send_job(32'd1, 1'b0);
		send_job(32'd1, 1'b0);
		send_job(32'h5555_5555, 1'b0);
		wait_idle();
		write_count(5'd16);
		send_job(32'd0, 1'b0);
		send_job(32'd0, 1'b0);
		wait_idle();

		// random phases, most start a fresh batch
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cnt = 16;
				1: cnt = 1;
				2: cnt = 31;
				3: cnt = 0;
				default: cnt = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) :
					$urandom_range(0, 31);
			endcase
			write_count(cnt[CNT_W-1:0]);
			stall_mode <= p[1:0];
			gaps_on = (p % 3) != 0;
			for (int j = 0; j < PHASE_JOBS; j++)
				send_job(pick_cost(),
					(j == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0));
			wait_idle();
		end

		stall_mode <= RX_ALWAYS;
		repeat (IDLE_PAUSE) @(posedge clk);
		$display("ran %0d jobs with %0d batch starts over %0d worker-count writes",
			jobs_sent, batch_starts, count_writes);
		$display("counts 0, 1, 5, 16, 31 and random; %0d results compared", results_checked);
		if (mismatch_count == 0 && jobs_in_flight == 0) begin
			$display("earliest_free_worker_scheduler: match");
		end else begin
			$display("earliest_free_worker_scheduler: mismatch");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ earliest_free_worker_scheduler.f @@
src/efws_pkg.sv
src/efws_heap_mem.sv
src/earliest_free_worker_scheduler.sv
src/efws_checker.sv
tb/sv/schedule_checker.sv
tb/sv/tb_top.sv
